[hdl/pms_pkg.sv]
// shared types and constants of the partitioned multi-stack
package pms_pkg;

    localparam int CMD_W = 1;
    localparam int SEL_W = 4;
    localparam int VAL_W = 32;
    localparam int STATUS_W = 2;
    localparam int NS_W = 5;
    localparam int CNT_W = 11;
    localparam int IDX_MAX_W = 8;
    localparam int ADDR_MAX_W = 16;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_STACKS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_SIZE = 4'd1;

    localparam logic [NS_W-1:0] NUM_STACKS_RST = 5'd1;
    localparam logic [CNT_W-1:0] TOTAL_SIZE_RST = 11'd1024;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP = 1'b1;

    localparam int CMD_LSB = 0;
    localparam int SEL_LSB = CMD_LSB + CMD_W;
    localparam int PUSH_LSB = SEL_LSB + SEL_W;
    localparam int S_DATA_W = ((PUSH_LSB + VAL_W + 7) / 8) * 8;

    localparam int STATUS_LSB = 0;
    localparam int POP_LSB = STATUS_LSB + STATUS_W;
    localparam int M_DATA_W = ((POP_LSB + VAL_W + 7) / 8) * 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic                  busy;
        logic [NS_W-1:0]       eff_stacks;
        logic                  we;
        logic [IDX_MAX_W-1:0]  idx;
        logic [ADDR_MAX_W-1:0] start;
        logic [CNT_W-1:0]      size;
    } part_ctl_t;

    typedef struct packed {
        op_t                   op;
        status_t               status;
        logic [ADDR_MAX_W-1:0] addr;
        logic [VAL_W-1:0]      data;
    } q_entry_t;

endpackage

[hdl/pms_cfg.sv]
// configuration registers and partition builder (divider and table sweep)
module pms_cfg #(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_STACKS  = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data,
    output pms_pkg::part_ctl_t              part
);

    localparam int IW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int NW = pms_pkg::NS_W;
    localparam int CW = pms_pkg::CNT_W;
    localparam int STEP_W = $clog2(CW);

    typedef enum logic [1:0] {
        S_LOAD,
        S_DIV,
        S_SWEEP,
        S_IDLE
    } state_t;

    state_t            state_reg;
    logic [NW-1:0]     num_stacks_reg;
    logic [CW-1:0]     total_size_reg;
    logic [NW-1:0]     eff_reg;
    logic [NW-1:0]     div_reg;
    logic [NW-1:0]     rem_reg;
    logic [CW-1:0]     quo_reg;
    logic [CW-1:0]     dvd_reg;
    logic [STEP_W-1:0] step_reg;
    logic [IW-1:0]     idx_reg;
    logic [CW-1:0]     pos_reg;

    logic [NW-1:0]     n_eff;
    logic [CW-1:0]     t_eff;
    logic [NW:0]       trial;
    logic              fits;
    logic [CW-1:0]     cur_size;
    logic              cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;

    always_comb
    begin
        if (num_stacks_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(num_stacks_reg) > MAX_STACKS)
        begin
            n_eff = NW'(MAX_STACKS);
        end
        else
        begin
            n_eff = num_stacks_reg;
        end
        if (int'(total_size_reg) > STORE_DEPTH)
        begin
            t_eff = CW'(STORE_DEPTH);
        end
        else
        begin
            t_eff = total_size_reg;
        end
    end

    // one restoring step per cycle
    assign trial = {rem_reg, dvd_reg[CW-1]};
    assign fits = (trial >= {1'b0, div_reg});

    always_comb
    begin
        if (int'(idx_reg) < int'(eff_reg))
        begin
            cur_size = quo_reg + CW'(int'(idx_reg) < int'(rem_reg));
        end
        else
        begin
            cur_size = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            num_stacks_reg <= pms_pkg::NUM_STACKS_RST;
            total_size_reg <= pms_pkg::TOTAL_SIZE_RST;
            eff_reg        <= NW'(1);
            div_reg        <= NW'(1);
            rem_reg        <= '0;
            quo_reg        <= '0;
            dvd_reg        <= '0;
            step_reg       <= '0;
            idx_reg        <= '0;
            pos_reg        <= '0;
        end
        else
        begin
            case (state_reg)
                S_LOAD:
                begin
                    eff_reg   <= n_eff;
                    div_reg   <= n_eff;
                    dvd_reg   <= t_eff;
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= fits ? NW'(trial - {1'b0, div_reg}) : NW'(trial);
                    quo_reg  <= {quo_reg[CW-2:0], fits};
                    dvd_reg  <= {dvd_reg[CW-2:0], 1'b0};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(CW - 1))
                    begin
                        idx_reg   <= '0;
                        pos_reg   <= '0;
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    pos_reg <= pos_reg + cur_size;
                    idx_reg <= idx_reg + IW'(1);
                    if (idx_reg == IW'(MAX_STACKS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_wr && cfg_index == pms_pkg::REG_NUM_STACKS)
            begin
                num_stacks_reg <= cfg_data[NW-1:0];
                state_reg      <= S_LOAD;
            end
            else if (cfg_wr && cfg_index == pms_pkg::REG_TOTAL_SIZE)
            begin
                total_size_reg <= cfg_data[CW-1:0];
                state_reg      <= S_LOAD;
            end
        end
    end

    always_comb
    begin
        part.busy       = (state_reg != S_IDLE);
        part.eff_stacks = eff_reg;
        part.we         = (state_reg == S_SWEEP);
        part.idx        = pms_pkg::IDX_MAX_W'(idx_reg);
        part.start      = pms_pkg::ADDR_MAX_W'(pos_reg);
        part.size       = cur_size;
    end

    a_write_rebuilds : assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (cfg_index == pms_pkg::REG_NUM_STACKS
                    || cfg_index == pms_pkg::REG_TOTAL_SIZE)) |=> part.busy)
        else $error("configuration write did not start a partition rebuild");

endmodule

[hdl/pms_front.sv]
// front end: accepts commands, checks them against stack counts and bounds
module pms_front #(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_STACKS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pms_pkg::part_ctl_t             part,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [pms_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output pms_pkg::q_entry_t              q_entry
);

    localparam int IW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = pms_pkg::CNT_W;
    localparam int SW = ((AW > CW) ? AW : CW) + 1;

    logic [CW-1:0] count_reg [MAX_STACKS];
    logic [AW-1:0] start_reg [MAX_STACKS];
    logic [CW-1:0] size_reg  [MAX_STACKS];

    logic                        cmd;
    logic [pms_pkg::SEL_W-1:0]   sel;
    logic [IW-1:0]               idx;
    logic [CW-1:0]               cnt;
    logic [CW-1:0]               sz;
    logic [SW-1:0]               top_addr;

    assign cmd = s_tdata[pms_pkg::CMD_LSB];
    assign sel = s_tdata[pms_pkg::SEL_LSB +: pms_pkg::SEL_W];
    assign idx = IW'(sel);
    assign cnt = count_reg[idx];
    assign sz = size_reg[idx];
    assign top_addr = SW'(start_reg[idx]) + SW'(cnt);

    assign s_tready = !part.busy && !q_full;
    assign q_push = s_tvalid && s_tready;

    always_comb
    begin
        q_entry.op     = pms_pkg::OP_NONE;
        q_entry.status = pms_pkg::ST_OK;
        q_entry.addr   = '0;
        q_entry.data   = s_tdata[pms_pkg::PUSH_LSB +: pms_pkg::VAL_W];
        if ({1'b0, sel} >= part.eff_stacks)
        begin
            q_entry.status = pms_pkg::ST_INVALID;
        end
        else if (cmd == pms_pkg::CMD_PUSH)
        begin
            if (cnt >= sz)
            begin
                q_entry.status = pms_pkg::ST_OVERFLOW;
            end
            else
            begin
                q_entry.op   = pms_pkg::OP_WRITE;
                q_entry.addr = pms_pkg::ADDR_MAX_W'(top_addr);
            end
        end
        else
        begin
            if (cnt == '0)
            begin
                q_entry.status = pms_pkg::ST_UNDERFLOW;
            end
            else
            begin
                q_entry.op   = pms_pkg::OP_READ;
                q_entry.addr = pms_pkg::ADDR_MAX_W'(top_addr - SW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (part.busy)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (q_push)
        begin
            case (q_entry.op)
                pms_pkg::OP_WRITE: count_reg[idx] <= cnt + CW'(1);
                pms_pkg::OP_READ:  count_reg[idx] <= cnt - CW'(1);
                default:           count_reg[idx] <= cnt;
            endcase
        end
    end

    // partition bounds, filled by the builder sweep
    always_ff @(posedge clk)
    begin
        if (part.we)
        begin
            start_reg[IW'(part.idx)] <= AW'(part.start);
            size_reg[IW'(part.idx)]  <= part.size;
        end
    end

    a_op_matches_status : assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> ((q_entry.status == pms_pkg::ST_OK)
                    == (q_entry.op != pms_pkg::OP_NONE)))
        else $error("queued operation disagrees with its status");

    a_push_counts_up : assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && q_entry.op == pms_pkg::OP_WRITE)
        |=> (count_reg[$past(idx)] == $past(cnt) + CW'(1)))
        else $error("accepted push did not grow the stack");

endmodule

[hdl/pms_fifo.sv]
// short command queue between front and back end
module pms_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pms_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output pms_pkg::q_entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pms_pkg::q_entry_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

[hdl/pms_back.sv]
// back end: word store access and result register
module pms_back #(
    parameter int STORE_DEPTH = 1024,
    parameter int WORD_BITS   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_not_empty,
    input  pms_pkg::q_entry_t              q_head,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [pms_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int VW = pms_pkg::VAL_W;

    logic [WORD_BITS-1:0] store_mem [STORE_DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 out_valid_reg;
    logic                 pop_ok_reg;
    pms_pkg::status_t     status_reg;

    logic [AW-1:0]        addr;
    logic [WORD_BITS-1:0] wdata;
    logic [VW-1:0]        pop_value;
    logic                 take;

    assign take = q_not_empty && (!out_valid_reg || m_tready);
    assign q_pop = take;
    assign addr = AW'(q_head.addr);

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            wdata[i] = (i < VW) ? q_head.data[i % VW] : 1'b0;
        end
        for (int i = 0; i < VW; i++)
        begin
            pop_value[i] = (i < WORD_BITS) ? (pop_ok_reg && rdata_reg[i % WORD_BITS]) : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pop_ok_reg    <= 1'b0;
            status_reg    <= pms_pkg::ST_OK;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
            pop_ok_reg    <= (q_head.op == pms_pkg::OP_READ);
            status_reg    <= q_head.status;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            case (q_head.op)
                pms_pkg::OP_WRITE: store_mem[addr] <= wdata;
                pms_pkg::OP_READ:  rdata_reg <= store_mem[addr];
                default:           rdata_reg <= rdata_reg;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(pms_pkg::M_DATA_W - pms_pkg::POP_LSB - VW){1'b0}},
                      pop_value, status_reg};

    a_drop_after_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(m_tready))
        else $error("result dropped without a transfer");

    a_pop_only_when_ok : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pop_ok_reg) |-> (status_reg == pms_pkg::ST_OK))
        else $error("popped word carried with a failure status");

endmodule

[hdl/partitioned_multi_stack_top.sv]
// top level of the partitioned multi-stack
// Several LIFO stacks share one word store split into contiguous partitions:
// each of num_stacks stacks gets total_size/num_stacks words, the first
// total_size mod num_stacks one word more. A push or pop is taken every cycle
// while the builder is idle and the queue is not full, and its result is
// registered in the back end; a four-entry command queue sits between the
// checking front end and the single-port store, so while the output stalls
// the input keeps flowing until four commands wait behind the held result.
// After reset and after every write to register 0 or 1 the partition builder
// runs (a load state, an 11-step divider, then one table entry a cycle),
// during which s_tready is low and all stacks are emptied; store contents
// are kept. Register 0 is num_stacks, register 1 is total_size.
module partitioned_multi_stack_top #(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_STACKS  = 16,
    parameter int WORD_BITS   = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd, stack_sel, push_value
    input  logic [pms_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, pop_value
    output logic [pms_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int Q_DEPTH = 4;

    pms_pkg::part_ctl_t part;
    pms_pkg::q_entry_t  q_entry;
    pms_pkg::q_entry_t  q_head;
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_not_empty;

    pms_cfg #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STACKS  (MAX_STACKS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .part      (part)
    );

    pms_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_STACKS  (MAX_STACKS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .part     (part),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    pms_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    pms_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
